### sv/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared types and constants of the triangle face normal pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tfn_pkg;

   localparam int unsigned IndexW  = 16;
   localparam int unsigned CoordW  = 16;
   localparam int unsigned NormW   = 16;
   localparam int unsigned MagW    = 33;          // |n_i| < 2^33
   localparam int unsigned SqW     = 2 * MagW;    // m_i^2
   localparam int unsigned SumW    = SqW + 2;     // sum of three squares
   localparam int unsigned RemW    = SumW + 1;    // division remainder
   localparam int unsigned QuoW    = 31;          // floor(m^2 * 2^30 / s) <= 2^30
   localparam int unsigned RootW   = 32;
   localparam int unsigned DivSteps  = QuoW;
   localparam int unsigned SqrtSteps = 16;
   localparam int unsigned FrontStages = 6;
   localparam int unsigned LaneStages  = DivSteps + SqrtSteps;
   localparam int unsigned TotalStages = FrontStages + LaneStages + 1;

   typedef logic [IndexW-1:0]        index_type;
   typedef logic signed [CoordW-1:0] coord_type;
   typedef logic signed [NormW-1:0]  norm_type;

   typedef struct packed {
      index_type index_a;
      index_type index_b;
      index_type index_c;
      coord_type ax;
      coord_type ay;
      coord_type az;
      coord_type bx;
      coord_type by_coord;
      coord_type bz;
      coord_type cx;
      coord_type cy;
      coord_type cz;
   } tri_type;

   // Per-item sideband that rides beside the normalization lanes.
   typedef struct packed {
      index_type  index_a;
      index_type  index_b;
      index_type  index_c;
      logic [2:0] neg;
      logic       zero;
   } side_type;

endpackage

`default_nettype wire

### sv/tfn_req_if.sv
// ----------------------------------------------------------------------------
// tfn_req_if
// Triangle input channel: valid/ready plus one triangle.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfn_req_if;
   logic                valid;
   logic                ready;
   tfn_pkg::index_type  index_a;
   tfn_pkg::index_type  index_b;
   tfn_pkg::index_type  index_c;
   tfn_pkg::coord_type  ax;
   tfn_pkg::coord_type  ay;
   tfn_pkg::coord_type  az;
   tfn_pkg::coord_type  bx;
   tfn_pkg::coord_type  by_coord;
   tfn_pkg::coord_type  bz;
   tfn_pkg::coord_type  cx;
   tfn_pkg::coord_type  cy;
   tfn_pkg::coord_type  cz;

   modport source (output valid, index_a, index_b, index_c, ax, ay, az,
                   bx, by_coord, bz, cx, cy, cz, input ready);
   modport sink   (input valid, index_a, index_b, index_c, ax, ay, az,
                   bx, by_coord, bz, cx, cy, cz, output ready);
endinterface

`default_nettype wire

### sv/tfn_rsp_if.sv
// ----------------------------------------------------------------------------
// tfn_rsp_if
// Normal result channel: valid/ready plus unit normal and indices.
// ----------------------------------------------------------------------------
`default_nettype none

interface tfn_rsp_if;
   logic                valid;
   logic                ready;
   tfn_pkg::norm_type   normal_x;
   tfn_pkg::norm_type   normal_y;
   tfn_pkg::norm_type   normal_z;
   logic                degenerate;
   tfn_pkg::index_type  out_index_a;
   tfn_pkg::index_type  out_index_b;
   tfn_pkg::index_type  out_index_c;

   modport source (output valid, normal_x, normal_y, normal_z, degenerate,
                   out_index_a, out_index_b, out_index_c, input ready);
   modport sink   (input valid, normal_x, normal_y, normal_z, degenerate,
                   out_index_a, out_index_b, out_index_c, output ready);
endinterface

`default_nettype wire

### sv/tfn_front.sv
// ----------------------------------------------------------------------------
// tfn_front
// Six-stage front end: edges, products, cross product, magnitudes, squares, sum.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_front (
   input  wire logic                         clock,
   input  wire logic                         adv,
   input  wire tfn_pkg::tri_type             tri_in,
   output logic [tfn_pkg::SqW-1:0]           sq_out [3],
   output logic [tfn_pkg::SumW-1:0]          sum_out,
   output tfn_pkg::side_type                 side_out
);

   localparam int unsigned EdgeW = tfn_pkg::CoordW + 1;
   localparam int unsigned ProdW = 2 * EdgeW;
   localparam int unsigned CrossW = ProdW + 1;

   // stage 1: edges
   logic signed [EdgeW-1:0] u_ff [3];
   logic signed [EdgeW-1:0] v_ff [3];
   tfn_pkg::side_type       side1_ff, side2_ff, side3_ff, side4_ff, side5_ff, side6_ff;
   // stage 2: products
   logic signed [ProdW-1:0] p_ff [6];
   // stage 3: cross product
   logic signed [CrossW-1:0] n_ff [3];
   // stage 4: magnitudes
   logic [tfn_pkg::MagW-1:0] m_ff [3];
   // stage 5: squares
   logic [tfn_pkg::SqW-1:0] sq5_ff [3];
   // stage 6: sum
   logic [tfn_pkg::SqW-1:0] sq6_ff [3];
   logic [tfn_pkg::SumW-1:0] sum_ff;

   tfn_pkg::side_type side1_in, side4_in;
   logic [CrossW-1:0] abs_in [3];

   always_comb begin
      side1_in = '0;
      side1_in.index_a = tri_in.index_a;
      side1_in.index_b = tri_in.index_b;
      side1_in.index_c = tri_in.index_c;
   end

   always_comb begin
      side4_in = side3_ff;
      for (int i = 0; i < 3; i++) begin
         side4_in.neg[i] = n_ff[i][CrossW-1];
         abs_in[i] = n_ff[i][CrossW-1] ? CrossW'(-n_ff[i]) : CrossW'(n_ff[i]);
      end
      side4_in.zero = (n_ff[0] == '0) && (n_ff[1] == '0) && (n_ff[2] == '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         u_ff[0] <= EdgeW'(tri_in.ax) - EdgeW'(tri_in.bx);
         u_ff[1] <= EdgeW'(tri_in.ay) - EdgeW'(tri_in.by_coord);
         u_ff[2] <= EdgeW'(tri_in.az) - EdgeW'(tri_in.bz);
         v_ff[0] <= EdgeW'(tri_in.ax) - EdgeW'(tri_in.cx);
         v_ff[1] <= EdgeW'(tri_in.ay) - EdgeW'(tri_in.cy);
         v_ff[2] <= EdgeW'(tri_in.az) - EdgeW'(tri_in.cz);
         side1_ff <= side1_in;

         p_ff[0] <= u_ff[1] * v_ff[2];
         p_ff[1] <= u_ff[2] * v_ff[1];
         p_ff[2] <= u_ff[2] * v_ff[0];
         p_ff[3] <= u_ff[0] * v_ff[2];
         p_ff[4] <= u_ff[0] * v_ff[1];
         p_ff[5] <= u_ff[1] * v_ff[0];
         side2_ff <= side1_ff;

         n_ff[0] <= CrossW'(p_ff[0]) - CrossW'(p_ff[1]);
         n_ff[1] <= CrossW'(p_ff[2]) - CrossW'(p_ff[3]);
         n_ff[2] <= CrossW'(p_ff[4]) - CrossW'(p_ff[5]);
         side3_ff <= side2_ff;

         for (int i = 0; i < 3; i++) begin
            m_ff[i] <= abs_in[i][tfn_pkg::MagW-1:0];
         end
         side4_ff <= side4_in;

         for (int i = 0; i < 3; i++) begin
            sq5_ff[i] <= tfn_pkg::SqW'(m_ff[i]) * tfn_pkg::SqW'(m_ff[i]);
         end
         side5_ff <= side4_ff;

         sq6_ff <= sq5_ff;
         sum_ff <= tfn_pkg::SumW'(sq5_ff[0]) + tfn_pkg::SumW'(sq5_ff[1])
                 + tfn_pkg::SumW'(sq5_ff[2]);
         side6_ff <= side5_ff;
      end
   end

   assign sq_out   = sq6_ff;
   assign sum_out  = sum_ff;
   assign side_out = side6_ff;

endmodule

`default_nettype wire

### sv/tfn_norm_lane.sv
// ----------------------------------------------------------------------------
// tfn_norm_lane
// One normal component: restoring divide of m^2*2^30 by s, one quotient
// bit per stage, then a digit-by-digit square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_norm_lane (
   input  wire logic                        clock,
   input  wire logic                        adv,
   input  wire logic [tfn_pkg::SqW-1:0]     sq_in,
   input  wire logic [tfn_pkg::SumW-1:0]    sum_in,
   output logic [tfn_pkg::RootW-1:0]        root_out
);

   localparam int unsigned RemW  = tfn_pkg::RemW;
   localparam int unsigned SumW  = tfn_pkg::SumW;
   localparam int unsigned QuoW  = tfn_pkg::QuoW;
   localparam int unsigned RootW = tfn_pkg::RootW;
   localparam int unsigned DivN  = tfn_pkg::DivSteps;
   localparam int unsigned SqrtN = tfn_pkg::SqrtSteps;

   logic [RemW-1:0]  rem_ff [1:DivN];
   logic [SumW-1:0]  den_ff [1:DivN];
   logic [QuoW-1:0]  quo_ff [1:DivN];
   logic [QuoW-1:0]  op_ff  [1:SqrtN];
   logic [RootW-1:0] res_ff [1:SqrtN];

   for (genvar i = 0; i < DivN; i++) begin : g_div
      logic [RemW-1:0] rem_cur;
      logic [SumW-1:0] den_cur;
      logic [QuoW-1:0] quo_cur;
      logic [RemW:0]   diff;
      logic            ge;
      logic [RemW-1:0] rem_in;
      if (i == 0) begin : g_first
         assign rem_cur = RemW'(sq_in);
         assign den_cur = sum_in;
         assign quo_cur = '0;
      end else begin : g_rest
         assign rem_cur = rem_ff[i];
         assign den_cur = den_ff[i];
         assign quo_cur = quo_ff[i];
      end
      assign diff   = {1'b0, rem_cur} - (RemW + 1)'(den_cur);
      assign ge     = !diff[RemW];
      assign rem_in = ge ? diff[RemW-1:0] : rem_cur;
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[i+1] <= {rem_in[RemW-2:0], 1'b0};
            den_ff[i+1] <= den_cur;
            quo_ff[i+1] <= {quo_cur[QuoW-2:0], ge};
         end
      end
   end

   for (genvar j = 0; j < SqrtN; j++) begin : g_sqrt
      localparam logic [RootW-1:0] OneBit = RootW'(1) << (2 * (SqrtN - 1 - j));
      logic [QuoW-1:0]  op_cur;
      logic [RootW-1:0] res_cur;
      logic [RootW-1:0] trial;
      logic             ge;
      if (j == 0) begin : g_first
         assign op_cur  = quo_ff[DivN];
         assign res_cur = '0;
      end else begin : g_rest
         assign op_cur  = op_ff[j];
         assign res_cur = res_ff[j];
      end
      assign trial = res_cur + OneBit;
      assign ge    = RootW'(op_cur) >= trial;
      always_ff @(posedge clock) begin
         if (adv) begin
            op_ff[j+1]  <= ge ? (op_cur - trial[QuoW-1:0]) : op_cur;
            res_ff[j+1] <= ge ? ((res_cur >> 1) + OneBit) : (res_cur >> 1);
         end
      end
   end

   assign root_out = res_ff[SqrtN];

endmodule

`default_nettype wire

### sv/triangle_face_normal.sv
// ----------------------------------------------------------------------------
// triangle_face_normal
// Unit face normal of a triangle, signed Q1.14, with vertex indices.
// ----------------------------------------------------------------------------
// Usage: drive one triangle per item on req_ch (three indices, vertices
// A, B, C in signed Q8.8); each item yields exactly one item on rsp_ch with
// the unit normal of (A-B) x (A-C), rounded to nearest, ties away from zero,
// and the indices passed through. A zero cross product gives a zero normal
// with degenerate set.
// Path from acceptance to rsp_ch.valid: six front stages (edges, products,
// cross, magnitude, squares, sum), 31 divide stages (one quotient bit of
// m^2*2^30/s each), 16 square-root stages (one root bit each) and the
// output register.
// Throughput: one item per cycle; req_ch.ready stays high unless the output
// register holds an item that the receiver has not taken.
// Stall: when rsp_ch.ready is low with a valid output, the whole pipeline,
// bubbles included, freezes in place, so nothing is dropped or repeated;
// with the output register empty every stage advances.
// Reset: synchronous, active high; clears all valid bits, the pipeline then
// accepts at once (no state beyond the pipeline).
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_face_normal (
   input  wire logic  clock,
   input  wire logic  reset,
   tfn_req_if.sink    req_ch,
   tfn_rsp_if.source  rsp_ch
);

   localparam int unsigned Total = tfn_pkg::TotalStages;
   localparam int unsigned LaneN = tfn_pkg::LaneStages;

   logic               adv;
   logic [Total-1:0]   valid_ff;
   logic [Total-1:0]   valid_in;
   tfn_pkg::tri_type   tri_in;

   logic [tfn_pkg::SqW-1:0]   sq [3];
   logic [tfn_pkg::SumW-1:0]  sum;
   tfn_pkg::side_type         side_front;
   tfn_pkg::side_type         side_ff [1:LaneN];
   logic [tfn_pkg::RootW-1:0] root [3];

   tfn_pkg::norm_type  norm_in [3];
   tfn_pkg::norm_type  norm_ff [3];
   tfn_pkg::side_type  side_out_ff;

   // Advance everything unless the output holds an item not yet taken.
   assign adv          = !valid_ff[Total-1] || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign valid_in     = {valid_ff[Total-2:0], req_ch.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      tri_in.index_a  = req_ch.index_a;
      tri_in.index_b  = req_ch.index_b;
      tri_in.index_c  = req_ch.index_c;
      tri_in.ax       = req_ch.ax;
      tri_in.ay       = req_ch.ay;
      tri_in.az       = req_ch.az;
      tri_in.bx       = req_ch.bx;
      tri_in.by_coord = req_ch.by_coord;
      tri_in.bz       = req_ch.bz;
      tri_in.cx       = req_ch.cx;
      tri_in.cy       = req_ch.cy;
      tri_in.cz       = req_ch.cz;
   end

   tfn_front u_front (
      .clock    (clock),
      .adv      (adv),
      .tri_in   (tri_in),
      .sq_out   (sq),
      .sum_out  (sum),
      .side_out (side_front)
   );

   for (genvar c = 0; c < 3; c++) begin : g_lane
      tfn_norm_lane u_lane (
         .clock    (clock),
         .adv      (adv),
         .sq_in    (sq[c]),
         .sum_in   (sum),
         .root_out (root[c])
      );
   end

   // Hold indices and sign/zero flags beside the lanes.
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[1] <= side_front;
         for (int k = 2; k <= LaneN; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // Round: root is floor(2*|n_i|*2^14/|n|); halve with carry-in, apply sign.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         logic [tfn_pkg::NormW-1:0] mag;
         mag = tfn_pkg::NormW'((root[c][tfn_pkg::NormW-1:0] + 16'd1) >> 1);
         if (side_ff[LaneN].zero) begin
            norm_in[c] = '0;
         end else if (side_ff[LaneN].neg[c]) begin
            norm_in[c] = -$signed(mag);
         end else begin
            norm_in[c] = $signed(mag);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         norm_ff     <= norm_in;
         side_out_ff <= side_ff[LaneN];
      end
   end

   assign rsp_ch.valid       = valid_ff[Total-1];
   assign rsp_ch.normal_x    = norm_ff[0];
   assign rsp_ch.normal_y    = norm_ff[1];
   assign rsp_ch.normal_z    = norm_ff[2];
   assign rsp_ch.degenerate  = side_out_ff.zero;
   assign rsp_ch.out_index_a = side_out_ff.index_a;
   assign rsp_ch.out_index_b = side_out_ff.index_b;
   assign rsp_ch.out_index_c = side_out_ff.index_c;

endmodule

`default_nettype wire

### tb/sv/tb_tfn_checker.sv
// ----------------------------------------------------------------------------
// tb_tfn_checker
// Passive checker: predicts the unit normal of every accepted triangle and
// compares each returned item against the oldest prediction, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_tfn_checker (
   input  wire logic clock,
   input  wire logic reset,
   tfn_req_if        req_ch,
   tfn_rsp_if        rsp_ch,
   output int        mismatch_count,
   output int        normals_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      tfn_pkg::norm_type  normal_x;
      tfn_pkg::norm_type  normal_y;
      tfn_pkg::norm_type  normal_z;
      logic               degenerate;
      tfn_pkg::index_type out_index_a;
      tfn_pkg::index_type out_index_b;
      tfn_pkg::index_type out_index_c;
   } normal_item_type;

   normal_item_type expected_normals[$];

   // Nearest Q1.14 magnitude of mag / sqrt(sum_sq), ties away from zero.
   function automatic logic [15:0] unit_magnitude(logic [127:0] mag,
                                                  logic [127:0] sum_sq);
      logic [127:0] target;
      logic [127:0] odd;
      logic [15:0]  q;
      logic [15:0]  cand;
      target = (mag * mag) << 30;
      q = '0;
      for (int b = 14; b >= 0; b--) begin
         cand = q | (16'd1 << b);
         if (cand <= 16'd16384) begin
            odd = 128'(2 * cand - 1);
            if (sum_sq * odd * odd <= target) q = cand;
         end
      end
      return q;
   endfunction

   function automatic normal_item_type face_normal(tfn_pkg::tri_type t);
      normal_item_type r;
      longint          u[3];
      longint          v[3];
      longint          n[3];
      logic [127:0]    m[3];
      logic [127:0]    sum_sq;
      logic [15:0]     q;
      u[0] = longint'(t.ax) - longint'(t.bx);
      u[1] = longint'(t.ay) - longint'(t.by_coord);
      u[2] = longint'(t.az) - longint'(t.bz);
      v[0] = longint'(t.ax) - longint'(t.cx);
      v[1] = longint'(t.ay) - longint'(t.cy);
      v[2] = longint'(t.az) - longint'(t.cz);
      n[0] = u[1] * v[2] - u[2] * v[1];
      n[1] = u[2] * v[0] - u[0] * v[2];
      n[2] = u[0] * v[1] - u[1] * v[0];
      r = '0;
      r.out_index_a = t.index_a;
      r.out_index_b = t.index_b;
      r.out_index_c = t.index_c;
      if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      for (int i = 0; i < 3; i++) m[i] = 128'(n[i] < 0 ? -n[i] : n[i]);
      sum_sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      for (int i = 0; i < 3; i++) begin
         q = unit_magnitude(m[i], sum_sq);
         if (n[i] < 0) q = -q;
         case (i)
            0: r.normal_x = q;
            1: r.normal_y = q;
            default: r.normal_z = q;
         endcase
      end
      return r;
   endfunction

   always @(posedge clock) begin
      tfn_pkg::tri_type t;
      normal_item_type  got;
      normal_item_type  want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            t = '{req_ch.index_a, req_ch.index_b, req_ch.index_c,
                  req_ch.ax, req_ch.ay, req_ch.az,
                  req_ch.bx, req_ch.by_coord, req_ch.bz,
                  req_ch.cx, req_ch.cy, req_ch.cz};
            expected_normals.push_back(face_normal(t));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.normal_x, rsp_ch.normal_y, rsp_ch.normal_z,
                    rsp_ch.degenerate, rsp_ch.out_index_a,
                    rsp_ch.out_index_b, rsp_ch.out_index_c};
            if (expected_normals.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%t: unexpected normal item %p", $realtime, got);
            end else begin
               want = expected_normals.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%t: normal mismatch\n  expected %p\n  actual   %p",
                              $realtime, want, got);
               end
            end
         end
      end
      normals_pending = expected_normals.size();
   end

   initial begin
      mismatch_count  = 0;
      normals_pending = 0;
   end

endmodule

`default_nettype wire

### tb/sv/tb_triangle_face_normal.sv
// ----------------------------------------------------------------------------
// tb_triangle_face_normal
// Stimulus and verdict for the triangle face normal pipeline: directed
// corner triangles, then random triangles with random idling on both sides,
// a drain pause, a long receiver hold-off and a stretch with no idling.
// Checking lives in tb_tfn_checker.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_triangle_face_normal;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit   = 200000;
   localparam int HoldCycles   = 300;   // far longer than the pipeline depth
   localparam int DrainCycles  = 80;    // beyond the pipeline depth
   localparam int IdlePercent  = 18;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   normals_pending;
   int   cycle_count;

   // Idling controls; the sender writes them, the receiver only reads.
   bit   quiet_stretch;   // no idling on either side while set
   int   hold_asks;       // each increment asks for one long receiver stall

   tfn_req_if req_ch ();
   tfn_rsp_if rsp_ch ();

   triangle_face_normal dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   tb_tfn_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .mismatch_count  (mismatch_count),
      .normals_pending (normals_pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: end the run if it hangs.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CycleLimit) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off per request.
   initial begin
      int hold_seen;
      hold_seen    = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            rsp_ch.ready = 1'b0;
            repeat (HoldCycles) @(negedge clock);
         end
         if (quiet_stretch) rsp_ch.ready = 1'b1;
         else rsp_ch.ready = ($urandom_range(99) >= IdlePercent);
      end
   end

   // Drive one triangle at the falling edge and hold it until accepted.
   task automatic offer_triangle(tfn_pkg::tri_type t);
      @(negedge clock);
      while (!quiet_stretch && $urandom_range(99) < IdlePercent) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      {req_ch.index_a, req_ch.index_b, req_ch.index_c,
       req_ch.ax, req_ch.ay, req_ch.az,
       req_ch.bx, req_ch.by_coord, req_ch.bz,
       req_ch.cx, req_ch.cy, req_ch.cz} = t;
      req_ch.valid = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Drop valid after the last item of a burst.
   task automatic release_channel();
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   // Random triangle: half small meshes, some full-range, some degenerate or flat.
   function automatic tfn_pkg::tri_type random_triangle();
      tfn_pkg::tri_type t;
      int               kind;
      t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      kind = $urandom_range(9);
      if (kind < 5) begin
         // keep coordinates near the origin, as a real mesh would
         t.ax = $signed(16'($urandom_range(2047))) - 16'sd1024;
         t.ay = $signed(16'($urandom_range(2047))) - 16'sd1024;
         t.az = $signed(16'($urandom_range(2047))) - 16'sd1024;
         t.bx = t.ax + $signed(16'($urandom_range(511))) - 16'sd256;
         t.by_coord = t.ay + $signed(16'($urandom_range(511))) - 16'sd256;
         t.bz = t.az + $signed(16'($urandom_range(511))) - 16'sd256;
         t.cx = t.ax + $signed(16'($urandom_range(511))) - 16'sd256;
         t.cy = t.ay + $signed(16'($urandom_range(511))) - 16'sd256;
         t.cz = t.az + $signed(16'($urandom_range(511))) - 16'sd256;
      end else if (kind == 5) begin
         // collinear: C repeats A or B
         if ($urandom_range(1)) {t.cx, t.cy, t.cz} = {t.ax, t.ay, t.az};
         else {t.cx, t.cy, t.cz} = {t.bx, t.by_coord, t.bz};
      end else if (kind == 6) begin
         // flat in one axis plane
         t.az = t.bz;
         t.cz = t.bz;
      end
      return t;
   endfunction

   initial begin
      tfn_pkg::tri_type t;
      reset         = 1'b1;
      quiet_stretch = 1'b0;
      hold_asks     = 0;
      req_ch.valid  = 1'b0;
      {req_ch.index_a, req_ch.index_b, req_ch.index_c,
       req_ch.ax, req_ch.ay, req_ch.az,
       req_ch.bx, req_ch.by_coord, req_ch.bz,
       req_ch.cx, req_ch.cy, req_ch.cz} = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed corners: all-zero (degenerate), axis-aligned unit faces,
      // both orientations, extremes of coordinates and indices, collinear.
      offer_triangle('0);
      offer_triangle('{16'd0, 16'd1, 16'd2, 0, 0, 0, 256, 0, 0, 0, 256, 0});
      offer_triangle('{16'd0, 16'd2, 16'd1, 0, 0, 0, 0, 256, 0, 256, 0, 0});
      offer_triangle('{16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 1, 0, 0, 0, 1});
      offer_triangle('{16'd7, 16'd8, 16'd9, 0, 0, 0, 0, 0, 1, 1, 0, 0});
      offer_triangle('{16'hFFFF, 16'd0, 16'h8000,
                       16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                       16'sh8000, 16'sh8000, 16'sh7FFF,
                       16'sh8000, 16'sh7FFF, 16'sh8000});
      offer_triangle('{16'd1, 16'd2, 16'd3,
                       16'sh8000, 16'sh8000, 16'sh8000,
                       16'sh7FFF, 16'sh8000, 16'sh8000,
                       16'sh8000, 16'sh7FFF, 16'sh8000});
      offer_triangle('{16'h5555, 16'hAAAA, 16'h1234,
                       16'sh8000, 16'sh7FFF, 16'sh8000,
                       16'sh7FFF, 16'sh8000, 16'sh7FFF,
                       16'sh8000, 16'sh8000, 16'sh7FFF});
      // collinear along a diagonal and a repeated vertex
      offer_triangle('{16'd3, 16'd4, 16'd5, 0, 0, 0, 100, 100, 100, 200, 200, 200});
      offer_triangle('{16'd3, 16'd4, 16'd5, 16'sh7FFF, 5, -5, 16'sh7FFF, 5, -5, 9, 9, 9});
      offer_triangle('{16'd10, 16'd11, 16'd12, 1, 1, 1, 1, 1, 1, 1, 1, 1});
      // skew faces: unequal components, negative signs on each axis
      offer_triangle('{16'd20, 16'd21, 16'd22, 0, 0, 0, 3, 0, 0, 0, 4, 5});
      offer_triangle('{16'd23, 16'd24, 16'd25, 0, 0, 0, -3, 1, 0, 2, 0, -7});
      offer_triangle('{16'd26, 16'd27, 16'd28, 10, -20, 30, -40, 50, -60, 70, 80, -90});
      offer_triangle('{16'd29, 16'd30, 16'd31, 0, 0, 0, 1, 1, 0, 1, 0, 1});
      offer_triangle('{16'd32, 16'd33, 16'd34, 16'sh7FFF, 0, 0, 0, 16'sh7FFF, 0,
                       0, 0, 16'sh7FFF});
      offer_triangle('{16'd35, 16'd36, 16'd37, 16'sh8000, 0, 0, 0, 16'sh8000, 0,
                       0, 0, 16'sh8000});

      // Random with idling on both sides.
      repeat (100) offer_triangle(random_triangle());

      // Pause the sender until every normal is back.
      release_channel();
      while (normals_pending != 0) @(posedge clock);

      // Long receiver hold-off while triangles keep coming: fill the pipe.
      hold_asks++;
      repeat (100) offer_triangle(random_triangle());

      // Stretch without any idling: full rate both ways.
      quiet_stretch = 1'b1;
      repeat (100) offer_triangle(random_triangle());
      quiet_stretch = 1'b0;

      repeat (100) offer_triangle(random_triangle());
      release_channel();

      // Drain, then allow the pipeline latency to pass.
      while (normals_pending != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (mismatch_count == 0 && normals_pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
